// File: sv/hrhp_pkg.sv
// Shared types, character codes and helper functions for the HTTP request head parser.
package hrhp_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_PENDING  = 2'd0,
      ST_FINISHED = 2'd1,
      ST_ERROR    = 2'd2
   } status_type;

   // Tag attached to the data byte.
   typedef enum logic [2:0] {
      TC_NONE   = 3'd0,
      TC_METHOD = 3'd1,
      TC_URI    = 3'd2,
      TC_NAME   = 3'd3,
      TC_VALUE  = 3'd4
   } token_class_type;

   // Character codes used by the parser.
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_DEL   = 8'h7f;
   localparam logic [7:0] CH_US    = 8'h1f;

   localparam logic [7:0] VER_MAX  = 8'hff;

   // Character classes of one byte.
   typedef struct packed {
      logic is_token;
      logic is_ctrl;
      logic is_num;
   } cls_type;

   // One parse result.
   typedef struct packed {
      status_type      status;
      token_class_type token_class;
      logic [7:0]      data_byte;
      logic            new_header;
      logic [7:0]      version_major;
      logic [7:0]      version_minor;
   } rsp_type;

   // acc * 10 + digit, held at 255 on overflow.
   function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
      logic [11:0] sum;
      begin
         sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, c[3:0]};
         acc_digit = (sum > {4'd0, VER_MAX}) ? VER_MAX : sum[7:0];
      end
   endfunction

endpackage

// File: sv/http_request_head_parser_top.sv
// Top level of the HTTP request head parser: input register, parse core, result register.
//
// Takes an HTTP request head one byte per request on the req_ stream and returns
// exactly one result per byte on the rsp_ stream, in order. A byte is taken every cycle
// while results are being drained; acceptance loads the input register, and the parse
// step then moves the byte from the input register into the result register that drives
// rsp_, waiting while that register holds an undrained result. Throughput is one byte
// per cycle while rsp_tready stays high. With rsp_tready held low, two requests fill
// the block and req_tready drops until the result register drains.
// req_tuser[0] set means restart: the parse returns to method start, the header-seen flag
// clears and the byte is ignored; version numbers are kept. Errors report status 2 and
// leave the parse state unchanged. Bytes tagged with a nonzero token class belong to the
// method, URI, header name or header value; new_header marks the first byte of a header
// name. Reset is synchronous, active high, and needs no clearing pass.
module http_request_head_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] status, [9:2] data_byte,
                                    // [17:10] version_major, [25:18] version_minor
   output logic [3:0]  rsp_tuser    // [2:0] token_class, [3] new_header
);
   import hrhp_pkg::*;

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       restart_ff;
   logic       out_vld_ff;
   rsp_type    rsp_ff;
   rsp_type    step_rsp;
   logic       advance;

   // The held byte moves into the result register when that slot is free or being drained.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         restart_ff <= req_tuser[0];
      end
   end

   hrhp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .restart (restart_ff),
      .result  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.version_minor, rsp_ff.version_major,
                        rsp_ff.data_byte, rsp_ff.status};
   assign rsp_tuser  = {rsp_ff.new_header, rsp_ff.token_class};

endmodule

// File: sv/hrhp_charclass.sv
// Character class decode of one byte: token character, control, decimal digit.
module hrhp_charclass (
   input  logic [7:0]       c,
   output hrhp_pkg::cls_type cls
);
   import hrhp_pkg::*;

   logic sep;

   always_comb begin
      case (c) inside
         8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
         8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, CH_SP, CH_HT: sep = 1'b1;
         default: sep = 1'b0;
      endcase
   end

   // Bytes 128 and up are neither controls nor token characters.
   always_comb begin
      cls.is_ctrl  = (c <= CH_US) || (c == CH_DEL);
      cls.is_token = !c[7] && !cls.is_ctrl && !sep;
      cls.is_num   = (c >= CH_ZERO) && (c <= CH_NINE);
   end

endmodule

// File: sv/hrhp_core.sv
// Parse state registers and the per-byte next-state and result logic.
module hrhp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,        // commit one byte this cycle
   input  logic [7:0]        in_byte,
   input  logic              restart,
   output hrhp_pkg::rsp_type result
);
   import hrhp_pkg::*;

   typedef enum logic [4:0] {
      PH_METHOD_START = 5'd0,
      PH_METHOD       = 5'd1,
      PH_URI          = 5'd2,
      PH_VER_H        = 5'd3,
      PH_VER_T1       = 5'd4,
      PH_VER_T2       = 5'd5,
      PH_VER_P        = 5'd6,
      PH_VER_SLASH    = 5'd7,
      PH_MAJOR_START  = 5'd8,
      PH_MAJOR        = 5'd9,
      PH_MINOR_START  = 5'd10,
      PH_MINOR        = 5'd11,
      PH_NL1          = 5'd12,
      PH_LINE_START   = 5'd13,
      PH_LWS          = 5'd14,
      PH_NAME         = 5'd15,
      PH_SPACE        = 5'd16,
      PH_VALUE        = 5'd17,
      PH_NL2          = 5'd18,
      PH_NL3          = 5'd19
   } phase_type;

   phase_type       phase_ff, phase_in, nxt;
   logic            header_seen_ff, header_seen_in, hs_nxt;
   logic [7:0]      major_ff, major_in, maj_nxt;
   logic [7:0]      minor_ff, minor_in, min_nxt;
   logic            ok;
   status_type      st;
   token_class_type tc;
   logic            nh;
   cls_type         cls;
   logic            lws;

   hrhp_charclass u_cls (
      .c   (in_byte),
      .cls (cls)
   );

   assign lws = (in_byte == CH_SP) || (in_byte == CH_HT);

   always_comb begin
      nxt     = phase_ff;
      hs_nxt  = header_seen_ff;
      maj_nxt = major_ff;
      min_nxt = minor_ff;
      ok      = 1'b1;
      st      = ST_PENDING;
      tc      = TC_NONE;
      nh      = 1'b0;
      unique case (phase_ff)
         PH_METHOD_START: begin
            if (cls.is_token) begin
               nxt = PH_METHOD;
               tc  = TC_METHOD;
            end else ok = 1'b0;
         end
         PH_METHOD: begin
            if (in_byte == CH_SP) nxt = PH_URI;
            else if (cls.is_token) tc = TC_METHOD;
            else ok = 1'b0;
         end
         PH_URI: begin
            if (in_byte == CH_SP) nxt = PH_VER_H;
            else if (cls.is_ctrl) ok = 1'b0;
            else tc = TC_URI;
         end
         PH_VER_H:  if (in_byte == CH_H) nxt = PH_VER_T1; else ok = 1'b0;
         PH_VER_T1: if (in_byte == CH_T) nxt = PH_VER_T2; else ok = 1'b0;
         PH_VER_T2: if (in_byte == CH_T) nxt = PH_VER_P;  else ok = 1'b0;
         PH_VER_P:  if (in_byte == CH_P) nxt = PH_VER_SLASH; else ok = 1'b0;
         PH_VER_SLASH: begin
            if (in_byte == CH_SLASH) begin
               maj_nxt = '0;
               min_nxt = '0;
               nxt     = PH_MAJOR_START;
            end else ok = 1'b0;
         end
         PH_MAJOR_START: begin
            if (cls.is_num) begin
               maj_nxt = acc_digit(major_ff, in_byte);
               nxt     = PH_MAJOR;
            end else ok = 1'b0;
         end
         PH_MAJOR: begin
            if (in_byte == CH_DOT) nxt = PH_MINOR_START;
            else if (cls.is_num) maj_nxt = acc_digit(major_ff, in_byte);
            else ok = 1'b0;
         end
         PH_MINOR_START: begin
            if (cls.is_num) begin
               min_nxt = acc_digit(minor_ff, in_byte);
               nxt     = PH_MINOR;
            end else ok = 1'b0;
         end
         PH_MINOR: begin
            if (in_byte == CH_CR) nxt = PH_NL1;
            else if (cls.is_num) min_nxt = acc_digit(minor_ff, in_byte);
            else ok = 1'b0;
         end
         PH_NL1, PH_NL2: begin
            if (in_byte == CH_LF) nxt = PH_LINE_START; else ok = 1'b0;
         end
         PH_LINE_START: begin
            if (in_byte == CH_CR) nxt = PH_NL3;
            else if (header_seen_ff && lws) nxt = PH_LWS;
            else if (cls.is_token) begin
               hs_nxt = 1'b1;
               nxt    = PH_NAME;
               tc     = TC_NAME;
               nh     = 1'b1;
            end else ok = 1'b0;
         end
         PH_LWS: begin
            if (in_byte == CH_CR) nxt = PH_NL2;
            else if (lws) nxt = PH_LWS;
            else if (cls.is_ctrl) ok = 1'b0;
            else begin
               nxt = PH_VALUE;
               tc  = TC_VALUE;
            end
         end
         PH_NAME: begin
            if (in_byte == CH_COLON) nxt = PH_SPACE;
            else if (cls.is_token) tc = TC_NAME;
            else ok = 1'b0;
         end
         PH_SPACE: if (in_byte == CH_SP) nxt = PH_VALUE; else ok = 1'b0;
         PH_VALUE: begin
            if (in_byte == CH_CR) nxt = PH_NL2;
            else if (cls.is_ctrl) ok = 1'b0;
            else tc = TC_VALUE;
         end
         // Finished head stays here; another LF finishes again.
         PH_NL3: if (in_byte == CH_LF) st = ST_FINISHED; else ok = 1'b0;
         default: ok = 1'b0;
      endcase

      // Errors leave every piece of state untouched.
      if (!ok) begin
         nxt     = phase_ff;
         hs_nxt  = header_seen_ff;
         maj_nxt = major_ff;
         min_nxt = minor_ff;
         st      = ST_ERROR;
         tc      = TC_NONE;
         nh      = 1'b0;
      end

      if (restart) begin
         phase_in       = PH_METHOD_START;
         header_seen_in = 1'b0;
         major_in       = major_ff;
         minor_in       = minor_ff;
         st             = ST_PENDING;
         tc             = TC_NONE;
         nh             = 1'b0;
      end else begin
         phase_in       = nxt;
         header_seen_in = hs_nxt;
         major_in       = maj_nxt;
         minor_in       = min_nxt;
      end

      result.status        = st;
      result.token_class   = tc;
      result.data_byte     = (tc != TC_NONE) ? in_byte : 8'd0;
      result.new_header    = nh;
      result.version_major = major_in;
      result.version_minor = minor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_METHOD_START;
         header_seen_ff <= 1'b0;
         major_ff       <= '0;
         minor_ff       <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         header_seen_ff <= header_seen_in;
         major_ff       <= major_in;
         minor_ff       <= minor_in;
      end
   end

`ifndef ASSERT_OFF
   a_err_holds_state: assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_ERROR |=>
         phase_ff == $past(phase_ff) && header_seen_ff == $past(header_seen_ff) &&
         major_ff == $past(major_ff) && minor_ff == $past(minor_ff))
      else $error("error byte changed parse state");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && restart |=> phase_ff == PH_METHOD_START && !header_seen_ff)
      else $error("restart did not return to method start");

   a_finish_phase: assert property (@(posedge clock) disable iff (reset)
      result.status == ST_FINISHED |-> phase_ff == PH_NL3 && in_byte == CH_LF)
      else $error("finished outside the final line feed");

   a_new_header_name: assert property (@(posedge clock) disable iff (reset)
      step && result.new_header |=> header_seen_ff && phase_ff == PH_NAME)
      else $error("new header without entering header name");

   a_cont_needs_header: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LWS |-> header_seen_ff)
      else $error("continuation line before any header");
`endif

endmodule
